/* rtl/c8ie_pkg.sv */
package c8ie_pkg;

  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  localparam logic [11:0] PC_RESET = 12'd512;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_SHIFT_USES_X = 3'd0;
  localparam logic [2:0] REG_KEEP_INDEX   = 3'd4;

  // System instructions in the 0NNN group.
  localparam logic [11:0] OP_CLS = 12'h0E0;
  localparam logic [11:0] OP_RET = 12'h0EE;

  // Key skip options in the EXNN group.
  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  // Options in the FXNN group.
  localparam logic [7:0] F_GET_DELAY = 8'h07;
  localparam logic [7:0] F_WAIT_KEY  = 8'h0A;
  localparam logic [7:0] F_SET_DELAY = 8'h15;
  localparam logic [7:0] F_SET_SOUND = 8'h18;
  localparam logic [7:0] F_ADD_INDEX = 8'h1E;
  localparam logic [7:0] F_FONT      = 8'h29;
  localparam logic [7:0] F_BCD       = 8'h33;
  localparam logic [7:0] F_DUMP      = 8'h55;
  localparam logic [7:0] F_LOAD      = 8'h65;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [7:0]  read_data;
    logic [7:0]  flag_register;
    logic        draw_event;
    logic        waiting_for_key;
    logic        sound_on;
  } result_t;

endpackage

/* rtl/chip8_instruction_executor_core.sv */
// CHIP-8 processor core.
// Input items arrive on the in_ stream: tuser holds the action, tdata holds
// address, write_data, keypad and random_byte from the lowest bit up. One
// result item per input item leaves on the out_ stream.
// The block takes one item at a time and is not ready while it works. A
// memory write or timer tick passes S_EXEC and then S_DONE, a frame read
// passes S_F2, S_EXEC and S_DONE, and an instruction is fetched through
// S_F0, S_F1 and S_F2 before S_EXEC and S_DONE. A sprite draw walks S_DRAW_RD,
// S_DRAW_WAIT and S_DRAW_A per row, plus S_DRAW_B when the row straddles two
// bytes on screen, and a closing S_DRAW_RD; a register dump takes one S_BLK
// per register, a load S_BLK and S_BLK_WAIT per register, and BCD one S_BCD per byte write.
// The pace is set by the single main memory port and the single frame port,
// both with registered reads, which every access walks through in turn.
// Reset sets pc to 512, clears registers, timers, stack pointer and frame
// store. A result stays on out_ until taken; no new item is accepted before.
// The configuration port is APB-like with pready always high.
module chip8_instruction_executor_core #(
  parameter int FONT_BASE = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: address[11:0], write_data[19:12], keypad[35:20], random_byte[43:36]
  input  logic [47:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: program_counter[11:0], read_data[19:12], flag_register[27:20],
  // draw_event[28], waiting_for_key[29], sound_on[30]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_F0, S_F1, S_F2, S_EXEC, S_DRAW_RD, S_DRAW_WAIT, S_DRAW_A,
    S_DRAW_B, S_BLK, S_BLK_WAIT, S_BCD, S_DONE
  } state_t;

  state_t      state_r;
  logic        shx_r, keep_r;
  logic [1:0]  act_r;
  logic [11:0] addr_r;
  logic [7:0]  wd_r, rnd_r;
  logic [15:0] keys_r;
  logic [7:0]  v_r [16];
  logic [11:0] stk_r [16];
  logic [3:0]  sp_r;
  logic [11:0] pc_r;
  logic [15:0] idx_r;
  logic [7:0]  dt_r, st_r;
  logic [15:0] op_r;
  logic [4:0]  cnt_r;
  logic        hit_r, drew_r, wait_r;
  logic [7:0]  sprite_r;
  logic [7:0]  rd_r;

  // Main memory, single port with registered read.
  logic [7:0]  mem [4096];
  logic        m_we;
  logic [11:0] m_addr;
  logic [7:0]  m_wd, m_q_r;
  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    m_q_r <= mem[m_addr];
  end

  // Frame store.
  logic       f_clr, f_we;
  logic [7:0] f_waddr, f_wdata, f_raddr, f_q;
  c8ie_frame u_frame (
    .clk(clk), .rst_n(rst_n), .clr(f_clr), .we(f_we), .waddr(f_waddr),
    .wdata(f_wdata), .raddr(f_raddr), .rdata(f_q)
  );

  // Instruction fields.
  logic [3:0] ox, oy, on;
  logic [7:0] nn, vx, vy;
  assign ox = op_r[11:8];
  assign oy = op_r[7:4];
  assign on = op_r[3:0];
  assign nn = op_r[7:0];
  assign vx = v_r[ox];
  assign vy = v_r[oy];

  // Sprite geometry.
  logic [5:0] px;
  logic [4:0] py;
  logic [2:0] colb, sh;
  logic [5:0] row;
  logic [7:0] nb_a, nb_b;
  logic [15:0] spr_wide;
  assign px = vx[5:0];
  assign py = vy[4:0];
  assign colb = px[5:3];
  assign sh = px[2:0];
  assign row = {1'b0, py} + {1'b0, cnt_r};
  assign spr_wide = {sprite_r, 8'd0} >> sh;
  assign nb_a = spr_wide[15:8];
  assign nb_b = spr_wide[7:0];

  // BCD digits of Vx: compares for the hundreds, a reciprocal multiply for the tens.
  logic [3:0]  hund, tens, ones;
  logic [7:0]  rem1, rem2;
  logic [15:0] tmul;
  always_comb begin
    hund = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
    rem1 = vx - ((hund == 4'd2) ? 8'd200 : (hund == 4'd1) ? 8'd100 : 8'd0);
    tmul = {8'd0, rem1} * 16'd205;
    tens = tmul[14:11];
    rem2 = rem1 - {1'b0, tens, 3'd0} - {3'd0, tens, 1'b0};
    ones = rem2[3:0];
  end

  // Lowest set key.
  logic [3:0] key_lo;
  always_comb begin
    key_lo = 4'd15;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) key_lo = 4'(k);
    end
  end

  logic [11:0] pc2;
  logic [11:0] idx12;
  assign pc2 = pc_r + 12'd2;
  assign idx12 = idx_r[11:0];

  // Memory and frame port control.
  always_comb begin
    m_we = 1'b0; m_addr = pc_r; m_wd = wd_r;
    f_clr = 1'b0; f_we = 1'b0; f_waddr = '0; f_wdata = '0;
    f_raddr = addr_r[7:0];
    case (state_r)
      S_F0: m_addr = pc_r;
      S_F1: m_addr = pc_r + 12'd1;
      S_EXEC: begin
        if (act_r == c8ie_pkg::ACT_WRITE) begin
          m_we = 1'b1; m_addr = addr_r;
        end
        if (act_r == c8ie_pkg::ACT_EXEC && op_r[15:12] == 4'h0 &&
            op_r[11:0] == c8ie_pkg::OP_CLS) f_clr = 1'b1;
      end
      S_DRAW_RD: m_addr = idx12 + 12'(cnt_r);
      S_DRAW_WAIT: f_raddr = {row[4:0], colb};
      S_DRAW_A: begin
        f_raddr = {row[4:0], colb + 3'd1};
        f_we = 1'b1; f_waddr = {row[4:0], colb}; f_wdata = f_q ^ nb_a;
      end
      S_DRAW_B: begin
        f_we = 1'b1; f_waddr = {row[4:0], colb + 3'd1}; f_wdata = f_q ^ nb_b;
      end
      S_BLK: begin
        m_addr = idx12 + 12'(cnt_r);
        if (nn == c8ie_pkg::F_DUMP) begin
          m_we = 1'b1; m_wd = v_r[cnt_r[3:0]];
        end
      end
      S_BLK_WAIT: m_addr = idx12 + 12'(cnt_r);
      S_BCD: begin
        m_we = 1'b1; m_addr = idx12 + 12'(cnt_r);
        m_wd = (cnt_r == 5'd0) ? {4'd0, hund} :
               (cnt_r == 5'd1) ? {4'd0, tens} : {4'd0, ones};
      end
      default: ;
    endcase
  end

  // Sequencer with all architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++) v_r[i] <= 8'd0;
      sp_r <= '0; pc_r <= c8ie_pkg::PC_RESET; idx_r <= '0;
      dt_r <= '0; st_r <= '0; drew_r <= 1'b0; wait_r <= 1'b0;
      shx_r <= 1'b0; keep_r <= 1'b0; rd_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == c8ie_pkg::REG_SHIFT_USES_X) shx_r <= cfg_pwdata[0];
        if (cfg_paddr == c8ie_pkg::REG_KEEP_INDEX) keep_r <= cfg_pwdata[0];
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          act_r <= in_tuser; addr_r <= in_tdata[11:0]; wd_r <= in_tdata[19:12];
          keys_r <= in_tdata[35:20]; rnd_r <= in_tdata[43:36];
          drew_r <= 1'b0; wait_r <= 1'b0; rd_r <= '0;
          state_r <= (in_tuser == c8ie_pkg::ACT_EXEC) ? S_F0 :
                     (in_tuser == c8ie_pkg::ACT_READ) ? S_F2 : S_EXEC;
        end
        S_F0: state_r <= S_F1;
        S_F1: begin op_r[15:8] <= m_q_r; state_r <= S_F2; end
        S_F2: begin
          if (act_r == c8ie_pkg::ACT_EXEC) op_r[7:0] <= m_q_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          cnt_r <= '0;
          case (act_r)
            c8ie_pkg::ACT_READ: rd_r <= (addr_r[11:8] == 4'd0) ? f_q : 8'd0;
            c8ie_pkg::ACT_TICK: begin
              if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
              if (st_r != 8'd0) st_r <= st_r - 8'd1;
            end
            c8ie_pkg::ACT_EXEC: begin
              pc_r <= pc2;
              case (op_r[15:12])
                4'h0: begin
                  if (op_r[11:0] == c8ie_pkg::OP_CLS) drew_r <= 1'b1;
                  else if (op_r[11:0] == c8ie_pkg::OP_RET) begin
                    sp_r <= sp_r - 4'd1; pc_r <= stk_r[sp_r - 4'd1];
                  end
                end
                4'h1: pc_r <= op_r[11:0];
                4'h2: begin
                  stk_r[sp_r] <= pc2; sp_r <= sp_r + 4'd1; pc_r <= op_r[11:0];
                end
                4'h3: if (vx == nn) pc_r <= pc2 + 12'd2;
                4'h4: if (vx != nn) pc_r <= pc2 + 12'd2;
                4'h5: if (vx == vy) pc_r <= pc2 + 12'd2;
                4'h6: v_r[ox] <= nn;
                4'h7: v_r[ox] <= vx + nn;
                4'h8: begin
                  logic [8:0] s9;
                  logic [7:0] b;
                  b = shx_r ? vx : vy;
                  s9 = '0;
                  case (on)
                    4'h0: v_r[ox] <= vy;
                    4'h1: v_r[ox] <= vx | vy;
                    4'h2: v_r[ox] <= vx & vy;
                    4'h3: v_r[ox] <= vx ^ vy;
                    4'h4: begin
                      s9 = {1'b0, vx} + {1'b0, vy};
                      v_r[ox] <= s9[7:0]; v_r[15] <= {7'd0, s9[8]};
                    end
                    4'h5: begin
                      v_r[ox] <= vx - vy; v_r[15] <= {7'd0, vx >= vy};
                    end
                    4'h7: begin
                      v_r[ox] <= vy - vx; v_r[15] <= {7'd0, vy >= vx};
                    end
                    4'h6: begin v_r[ox] <= b >> 1; v_r[15] <= {7'd0, b[0]}; end
                    4'hE: begin v_r[ox] <= b << 1; v_r[15] <= {7'd0, b[7]}; end
                    default: ;
                  endcase
                end
                4'h9: if (vx != vy) pc_r <= pc2 + 12'd2;
                4'hA: idx_r <= {4'd0, op_r[11:0]};
                4'hB: pc_r <= op_r[11:0] + {4'd0, v_r[0]};
                4'hC: v_r[ox] <= rnd_r & nn;
                4'hD: begin
                  drew_r <= 1'b1; hit_r <= 1'b0;
                  state_r <= (on == 4'd0) ? S_DONE : S_DRAW_RD;
                  if (on == 4'd0) v_r[15] <= 8'd0;
                end
                4'hE: begin
                  if ((nn == c8ie_pkg::KEY_DOWN && keys_r[vx[3:0]]) ||
                      (nn == c8ie_pkg::KEY_UP && !keys_r[vx[3:0]])) pc_r <= pc2 + 12'd2;
                end
                default: begin
                  case (nn)
                    c8ie_pkg::F_GET_DELAY: v_r[ox] <= dt_r;
                    c8ie_pkg::F_WAIT_KEY: begin
                      if (keys_r != 16'd0) v_r[ox] <= {4'd0, key_lo};
                      else begin pc_r <= pc_r; wait_r <= 1'b1; end
                    end
                    c8ie_pkg::F_SET_DELAY: dt_r <= vx;
                    c8ie_pkg::F_SET_SOUND: st_r <= vx;
                    c8ie_pkg::F_ADD_INDEX: idx_r <= idx_r + {8'd0, vx};
                    c8ie_pkg::F_FONT: idx_r <= 16'(vx * 11'd5) + 16'(FONT_BASE);
                    c8ie_pkg::F_BCD: state_r <= S_BCD;
                    c8ie_pkg::F_DUMP, c8ie_pkg::F_LOAD: state_r <= S_BLK;
                    default: ;
                  endcase
                end
              endcase
            end
            default: ;
          endcase
        end
        S_DRAW_RD: begin
          if (row >= 6'd32 || cnt_r == {1'b0, on}) begin
            v_r[15] <= {7'd0, hit_r}; state_r <= S_DONE;
          end else state_r <= S_DRAW_WAIT;
        end
        S_DRAW_WAIT: begin sprite_r <= m_q_r; state_r <= S_DRAW_A; end
        S_DRAW_A: begin
          if ((f_q & nb_a) != 8'd0) hit_r <= 1'b1;
          if (sh != 3'd0 && colb != 3'd7) state_r <= S_DRAW_B;
          else begin cnt_r <= cnt_r + 5'd1; state_r <= S_DRAW_RD; end
        end
        S_DRAW_B: begin
          if ((f_q & nb_b) != 8'd0) hit_r <= 1'b1;
          cnt_r <= cnt_r + 5'd1; state_r <= S_DRAW_RD;
        end
        S_BLK: begin
          if (nn == c8ie_pkg::F_DUMP) begin
            if (cnt_r[3:0] == ox) begin
              if (!keep_r) idx_r <= idx_r + {12'd0, ox} + 16'd1;
              state_r <= S_DONE;
            end else cnt_r <= cnt_r + 5'd1;
          end else state_r <= S_BLK_WAIT;
        end
        S_BLK_WAIT: begin
          v_r[cnt_r[3:0]] <= m_q_r;
          if (cnt_r[3:0] == ox) begin
            if (!keep_r) idx_r <= idx_r + {12'd0, ox} + 16'd1;
            state_r <= S_DONE;
          end else begin cnt_r <= cnt_r + 5'd1; state_r <= S_BLK; end
        end
        S_BCD: begin
          if (cnt_r == 5'd2) state_r <= S_DONE;
          else cnt_r <= cnt_r + 5'd1;
        end
        S_DONE: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata = {1'b0, st_r != 8'd0, wait_r, drew_r, v_r[15], rd_r, pc_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == c8ie_pkg::REG_SHIFT_USES_X) ? {31'd0, shx_r} :
                      (cfg_paddr == c8ie_pkg::REG_KEEP_INDEX) ? {31'd0, keep_r} : 32'd0;

  // Checks on the sequencer.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_wait_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29] |-> !out_tdata[28]) else $error("wait and draw");
endmodule

/* rtl/c8ie_frame.sv */
// Frame store: 256 bytes, one read and one write port, registered read data.
// A valid bit per byte gives the cleared value after reset or a screen clear.
module c8ie_frame (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clr,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);
  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [7:0]   q_r;
  logic         qv_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Storage array and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r  <= mem[raddr];
    qv_r <= vld_r[raddr];
  end

  assign rdata = qv_r ? q_r : 8'd0;
endmodule
